// ===== src/skt_pkg.sv =====
package skt_pkg;

    localparam int HOST_W  = 64;
    localparam int START_W = 31;
    localparam int WIN_W   = 64;
    localparam int SINCE_W = 31;

    // one table row: three-part key and its payload
    typedef struct packed {
        logic [SINCE_W-1:0] host_since;
        logic               host_kind;
        logic               host_active;
        logic [WIN_W-1:0]   host_window_id;
        logic               window_kind;
        logic [WIN_W-1:0]   window_id;
        logic [START_W-1:0] window_start;
        logic [HOST_W-1:0]  host_key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int IN_DATA_W = ((ENTRY_W + 7) / 8) * 8;

    typedef enum logic {
        MODE_FIND = 1'b0,
        MODE_CLEAR = 1'b1
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } skt_state_t;

endpackage

// ===== src/skt_cell.sv =====
module skt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmp_en,
    input  skt_pkg::entry_t      cmp_key,
    input  logic [CNT_W-1:0]     fill_count,
    input  logic                 shift_en,
    input  skt_pkg::entry_t      new_entry,
    input  skt_pkg::entry_t      left_entry,
    input  logic                 left_below,
    output skt_pkg::entry_t      entry,
    output logic                 below,
    output logic                 equal
);

    skt_pkg::entry_t entry_reg;
    logic            below_reg;
    logic            equal_reg;
    logic            active;
    logic [skt_pkg::HOST_W+skt_pkg::START_W+skt_pkg::WIN_W-1:0] own_k, req_k;

    assign active = CNT_W'(INDEX) < fill_count;
    assign own_k  = {entry_reg.host_key, entry_reg.window_start, entry_reg.window_id};
    assign req_k  = {cmp_key.host_key, cmp_key.window_start, cmp_key.window_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= 1'b0;
            equal_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            below_reg <= active && (own_k < req_k);
            equal_reg <= active && (own_k == req_k);
        end
    end

    // insert: the boundary cell takes the new row, every cell above it takes its neighbour's
    always_ff @(posedge clk)
    begin
        if (shift_en && !below_reg)
        begin
            if (left_below)
                entry_reg <= new_entry;
            else
                entry_reg <= left_entry;
        end
    end

    assign entry = entry_reg;
    assign below = below_reg;
    assign equal = equal_reg;

endmodule

// ===== src/sorted_key_table_find_or_insert.sv =====
// The result is registered in ST_UPDATE, which follows the input transfer; it waits there
// only while the output register is still held by m_tready low.
// A new request is taken only in ST_IDLE, not before the last one is through: at the transfer
// every cell compares its row with the key; ST_UPDATE shifts the rows and registers the result.
// Reset (rst_n low, asynchronous): table empty, no result pending.
module sorted_key_table_find_or_insert #(
    parameter int TABLE_DEPTH = 64,
    localparam int POS_W = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_DATA_W = ((2 * POS_W + 100 + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // host_key, window_start, window_id, window_kind, host_window_id,
    // host_active, host_kind, host_since
    input  logic [skt_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // position, was_inserted, table_full, out_window_kind, out_host_window_id,
    // out_host_active, out_host_kind, out_host_since, entry_total
    output logic [OUT_DATA_W-1:0]          m_tdata
);

    localparam int RES_W = 2 * POS_W + 100;

    skt_pkg::skt_state_t state_reg, state_next;
    skt_pkg::entry_t     req_reg;
    skt_pkg::entry_t     in_entry;
    logic                mode_reg;
    logic [POS_W-1:0]    fill_reg, fill_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0]    res_reg, res_next;

    skt_pkg::entry_t     cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] below_vec, equal_vec;
    logic [TABLE_DEPTH:0]   boundary;

    logic accept, out_free, upd_fire, found, is_insert, is_full;
    logic [POS_W-1:0] pos;
    skt_pkg::entry_t  hit_entry, res_entry;

    assign in_entry = s_tdata[skt_pkg::ENTRY_W-1:0];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        skt_cell #(
            .INDEX (g),
            .CNT_W (POS_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmp_en     (accept),
            .cmp_key    (in_entry),
            .fill_count (fill_reg),
            .shift_en   (upd_fire && is_insert),
            .new_entry  (req_reg),
            .left_entry ((g == 0) ? req_reg : cell_entry[(g == 0) ? 0 : g - 1]),
            .left_below ((g == 0) ? 1'b1 : below_vec[(g == 0) ? 0 : g - 1]),
            .entry      (cell_entry[g]),
            .below      (below_vec[g]),
            .equal      (equal_vec[g])
        );
    end

    // rows are sorted, so below_vec is a thermometer; boundary marks its edge
    always_comb
    begin
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            boundary[i] = ((i == 0) ? 1'b1 : below_vec[(i == 0) ? 0 : i - 1])
                        & ((i == TABLE_DEPTH) ? 1'b1
                                              : !below_vec[(i == TABLE_DEPTH) ? 0 : i]);
        end
    end

    always_comb
    begin
        pos = '0;
        hit_entry = '0;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            if (boundary[i])
                pos = pos | POS_W'(i);
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (equal_vec[i])
                hit_entry = hit_entry | cell_entry[i];
        end
    end

    assign found     = |equal_vec;
    assign is_full   = fill_reg == POS_W'(TABLE_DEPTH);
    assign is_insert = (mode_reg == skt_pkg::MODE_FIND) && !found && !is_full;
    assign upd_fire  = (state_reg == skt_pkg::ST_UPDATE) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = skt_pkg::ST_UPDATE;
            end
            skt_pkg::ST_UPDATE:
            begin
                if (out_free)
                    state_next = skt_pkg::ST_IDLE;
            end
            default: state_next = skt_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        s_tready      = 1'b0;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        res_next      = res_reg;
        res_entry     = '0;
        case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            skt_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (mode_reg == skt_pkg::MODE_CLEAR)
                    begin
                        fill_next = '0;
                        res_next  = '0;
                    end
                    else
                    begin
                        if (found)
                            res_entry = hit_entry;
                        else if (is_insert)
                        begin
                            res_entry = req_reg;
                            fill_next = fill_reg + 1'b1;
                        end
                        res_next = {fill_next,
                                    res_entry.host_since,
                                    res_entry.host_kind,
                                    res_entry.host_active,
                                    res_entry.host_window_id,
                                    res_entry.window_kind,
                                    is_full && !found,
                                    is_insert,
                                    pos};
                    end
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= skt_pkg::ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= in_entry;
            mode_reg <= s_tuser;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, res_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= POS_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == skt_pkg::ST_UPDATE |-> $onehot0(equal_vec))
        else $error("key matched in more than one row");

    a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == skt_pkg::ST_UPDATE |-> $onehot(boundary))
        else $error("rows out of order");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire && is_insert |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("insert did not grow the table");

endmodule

// ===== tb/skt_reply_checker.sv =====
module skt_reply_checker #(
    parameter int DEPTH = 64,
    parameter int OUT_W = 120
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // host_key, window_start, window_id, window_kind, host_window_id,
    // host_active, host_kind, host_since
    input  logic [skt_pkg::IN_DATA_W-1:0] s_tdata,
    // mode
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // position, was_inserted, table_full, out_window_kind, out_host_window_id,
    // out_host_active, out_host_kind, out_host_since, entry_total
    input  logic [OUT_W-1:0]              m_tdata,
    output int                            fail_count,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // lowest field last, so the packed layout matches m_tdata from bit 0 up
    typedef struct packed {
        logic [6:0]                  entry_total;
        logic [skt_pkg::SINCE_W-1:0] host_since;
        logic                        host_kind;
        logic                        host_active;
        logic [skt_pkg::WIN_W-1:0]   host_window_id;
        logic                        window_kind;
        logic                        table_full;
        logic                        was_inserted;
        logic [6:0]                  position;
    } lookup_reply_t;

    localparam int REPLY_W = $bits(lookup_reply_t);
    localparam int KEY_W   = skt_pkg::HOST_W + skt_pkg::START_W + skt_pkg::WIN_W;

    skt_pkg::entry_t rows [DEPTH];
    int              row_count;
    lookup_reply_t   replies_due [$];

    initial begin
        fail_count = 0;
        outstanding = 0;
        row_count = 0;
    end

    function automatic lookup_reply_t find_or_insert(input skt_pkg::mode_t mode,
                                                     input skt_pkg::entry_t req);
        lookup_reply_t r;
        int pos;
        int i;
        logic [KEY_W-1:0] want_key;
        r = '0;
        if (mode == skt_pkg::MODE_CLEAR) begin
            row_count = 0;
            return r;
        end
        want_key = {req.host_key, req.window_start, req.window_id};
        // lower bound over the whole key, compared as one wide number
        pos = 0;
        while (pos < row_count &&
               {rows[pos].host_key, rows[pos].window_start, rows[pos].window_id} < want_key)
            pos++;
        r.position = pos[6:0];
        if (pos < row_count &&
            {rows[pos].host_key, rows[pos].window_start, rows[pos].window_id} == want_key) begin
            // hit: table untouched, stored payload returned
        end else if (row_count >= DEPTH) begin
            r.table_full = 1'b1;
            r.entry_total = row_count[6:0];
            return r;
        end else begin
            for (i = row_count; i > pos; i--)
                rows[i] = rows[i - 1];
            rows[pos] = req;
            row_count++;
            r.was_inserted = 1'b1;
        end
        r.window_kind = rows[pos].window_kind;
        r.host_window_id = rows[pos].host_window_id;
        r.host_active = rows[pos].host_active;
        r.host_kind = rows[pos].host_kind;
        r.host_since = rows[pos].host_since;
        r.entry_total = row_count[6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        lookup_reply_t got;
        lookup_reply_t want;
        if (!rst_n) begin
            row_count = 0;
            replies_due.delete();
            outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = lookup_reply_t'(m_tdata[REPLY_W-1:0]);
                if (replies_due.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("position", 64'(want.position), 64'(got.position));
                    check_field("was_inserted", 64'(want.was_inserted),
                                64'(got.was_inserted));
                    check_field("table_full", 64'(want.table_full), 64'(got.table_full));
                    check_field("out_window_kind", 64'(want.window_kind),
                                64'(got.window_kind));
                    check_field("out_host_window_id", want.host_window_id,
                                got.host_window_id);
                    check_field("out_host_active", 64'(want.host_active),
                                64'(got.host_active));
                    check_field("out_host_kind", 64'(want.host_kind), 64'(got.host_kind));
                    check_field("out_host_since", 64'(want.host_since),
                                64'(got.host_since));
                    check_field("entry_total", 64'(want.entry_total),
                                64'(got.entry_total));
                end
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(find_or_insert(
                    skt_pkg::mode_t'(s_tuser),
                    skt_pkg::entry_t'(s_tdata[skt_pkg::ENTRY_W-1:0])));
            outstanding = replies_due.size();
        end
    end

endmodule

// ===== tb/tb_sorted_key_table_find_or_insert.sv =====
module tb_sorted_key_table_find_or_insert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int POS_W        = 7;
    localparam int OUT_W        = ((2 * POS_W + 100 + 7) / 8) * 8;
    localparam int PAD_W        = skt_pkg::IN_DATA_W - skt_pkg::ENTRY_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 10;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [skt_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [OUT_W-1:0]              m_tdata;

    int   fail_count;
    int   outstanding;
    logic in_fire = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic stall_on = 1'b0;
    event rx_hold_start;

    logic [63:0] host_pool [5];
    logic [30:0] start_pool [4];
    logic [63:0] id_pool [4];

    sorted_key_table_find_or_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    skt_reply_checker #(
        .DEPTH (DEPTH),
        .OUT_W (OUT_W)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        in_fire <= ((s_tvalid && s_tready) === 1'b1);

    always @(negedge clk) begin
        if (stall_on)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, so the block backs up onto its input
    initial begin
        forever begin
            @(rx_hold_start);
            stall_on <= 1'b1;
            repeat (STALL_CYCLES) @(negedge clk);
            stall_on <= 1'b0;
        end
    end

    initial begin
        int n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge clk);
            n++;
        end
        $display("FAIL sorted_key_table_find_or_insert");
        $finish;
    end

    // called at a falling edge; returns at a falling edge after the transfer, later if an idle gap follows
    task automatic send_request(input skt_pkg::mode_t m, input skt_pkg::entry_t e);
        s_tvalid <= 1'b1;
        s_tdata <= {{PAD_W{1'b0}}, e};
        s_tuser <= m;
        do @(negedge clk); while (!in_fire);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_key(input skt_pkg::mode_t m, input logic [63:0] h,
                            input logic [30:0] s, input logic [63:0] w,
                            input logic pay_ones);
        skt_pkg::entry_t e;
        if (pay_ones)
            e = {skt_pkg::ENTRY_W{1'b1}};
        else
            e = '0;
        e.host_key = h;
        e.window_start = s;
        e.window_id = w;
        send_request(m, e);
    endtask

    // keys mostly from a small pool so lookups hit; the rest are fresh
    function automatic skt_pkg::entry_t make_request(input int fresh_pct);
        skt_pkg::entry_t e;
        logic [31:0] r;
        r = $urandom;
        e.window_kind = r[0];
        e.host_active = r[1];
        e.host_kind = r[2];
        e.host_window_id = {$urandom, $urandom};
        r = $urandom;
        e.host_since = r[30:0];
        if ($urandom_range(99) < fresh_pct) begin
            e.host_key = {$urandom, $urandom};
            r = $urandom;
            e.window_start = r[30:0];
            e.window_id = {$urandom, $urandom};
        end else begin
            e.host_key = host_pool[$urandom_range(4)];
            e.window_start = start_pool[$urandom_range(3)];
            e.window_id = id_pool[$urandom_range(3)];
        end
        return e;
    endfunction

    task automatic random_run(input int count, input int clear_pct, input int fresh_pct);
        skt_pkg::mode_t m;
        for (int i = 0; i < count; i++) begin
            m = ($urandom_range(99) < clear_pct) ? skt_pkg::MODE_CLEAR : skt_pkg::MODE_FIND;
            send_request(m, make_request(fresh_pct));
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        logic [31:0] r;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        host_pool[0] = '0;
        host_pool[1] = MAX64;
        for (int i = 2; i < 5; i++)
            host_pool[i] = {$urandom, $urandom};
        start_pool[0] = '0;
        start_pool[1] = MAX31;
        for (int i = 2; i < 4; i++) begin
            r = $urandom;
            start_pool[i] = r[30:0];
        end
        id_pool[0] = '0;
        id_pool[1] = MAX64;
        for (int i = 2; i < 4; i++)
            id_pool[i] = {$urandom, $urandom};

        // directed: extremes, ordering on each key part, hits, clears
        send_key(skt_pkg::MODE_CLEAR, MAX64, MAX31, MAX64, 1'b1);
        send_key(skt_pkg::MODE_FIND, '0, '0, '0, 1'b0);
        send_key(skt_pkg::MODE_FIND, MAX64, MAX31, MAX64, 1'b1);
        send_key(skt_pkg::MODE_FIND, '0, '0, '0, 1'b1);
        send_key(skt_pkg::MODE_FIND, MAX64, MAX31, MAX64, 1'b0);
        send_key(skt_pkg::MODE_FIND, '0, '0, 64'd1, 1'b1);
        send_key(skt_pkg::MODE_FIND, '0, 31'd1, '0, 1'b0);
        send_key(skt_pkg::MODE_FIND, 64'd1, '0, '0, 1'b1);
        send_key(skt_pkg::MODE_FIND, MAX64, MAX31, MAX64 - 64'd1, 1'b0);
        send_key(skt_pkg::MODE_FIND, MAX64, MAX31 - 31'd1, MAX64, 1'b1);
        send_key(skt_pkg::MODE_FIND, MAX64 - 64'd1, MAX31, MAX64, 1'b0);
        send_key(skt_pkg::MODE_FIND, '0, 31'd1, '0, 1'b1);
        send_key(skt_pkg::MODE_FIND, 64'd1, '0, '0, 1'b0);
        send_key(skt_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
        send_key(skt_pkg::MODE_FIND, '0, 31'd1, '0, 1'b1);
        send_key(skt_pkg::MODE_FIND, '0, 31'd1, '0, 1'b0);
        send_key(skt_pkg::MODE_FIND, '0, '0, '0, 1'b0);
        send_key(skt_pkg::MODE_CLEAR, MAX64, MAX31, MAX64, 1'b1);
        drain();

        tx_idle_pct <= 13;
        rx_idle_pct <= 56;
        random_run(60, 4, 20);
        -> rx_hold_start;
        random_run(60, 4, 20);
        drain();

        // one clear, then a long run without clears, so the table fills and new keys get refused
        tx_idle_pct <= 56;
        rx_idle_pct <= 13;
        send_key(skt_pkg::MODE_CLEAR, '0, '0, '0, 1'b0);
        random_run(150, 0, 35);
        random_run(20, 10, 20);
        drain();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        random_run(130, 2, 20);
        drain();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS sorted_key_table_find_or_insert");
        else
            $display("FAIL sorted_key_table_find_or_insert");
        $finish;
    end

endmodule

// ===== files.f =====
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table_find_or_insert.sv
tb/skt_reply_checker.sv
tb/tb_sorted_key_table_find_or_insert.sv
